// File: sv/itrg_pkg.sv
// Shared types and constants for the interval timer rate generator.
package itrg_pkg;

  // Field widths of one transaction in each direction.
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned PORT_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned MASK_W   = 3;

  // Depth of each queue; a power of two, at least two.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Bus opcodes.
  localparam logic [OPCODE_W-1:0] OPC_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OPC_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OPC_TICK  = 2'd2;

  // The command port; the other ports are channel data ports.
  localparam logic [PORT_W-1:0] CMD_PORT = 2'd3;

  // Access codes in bits 5:4 of a command byte.
  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOHI  = 2'd3;

  // Operation kinds handed from the decoder to the execution side.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_MODE,
    OP_WRITE,
    OP_READ,
    OP_TICK
  } op_kind_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PORT_W-1:0]   port;
    logic [BYTE_W-1:0]   write_data;
  } item_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic [MASK_W-1:0] pulse_mask;
  } item_out_t;

  typedef struct packed {
    op_kind_e          kind;
    logic [1:0]        ch;
    logic [BYTE_W-1:0] data;
  } op_t;

endpackage

// File: sv/interval_timer_rate_generator.sv
// Top level: decoder, operation queue, channel execution and result queue.
// A result passes through the operation queue and the result queue, both registered.
// Throughput: one transaction per cycle while neither queue is full; each queue
// holds two entries, and the execution stage retires one operation per cycle.
// Reset: rst_ni clears both queues, the live counts, latch flags, toggles and arm flags.
module interval_timer_rate_generator import itrg_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  item_in_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output item_out_t out_item_o
);

  op_t       op_dec, op_exe;
  item_out_t res;
  logic      op_empty, res_full, go;

  // Classify incoming transactions.
  itrg_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .item_i(in_item_i),
    .op_o  (op_dec)
  );

  // Operation queue between decoder and execution.
  itrg_fifo #(.item_t(op_t), .DEPTH(QUEUE_DEPTH)) u_op_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (op_dec),
    .full_o (full),
    .pop_i  (go),
    .empty_o(op_empty),
    .data_o (op_exe)
  );

  // Execute when an operation waits and the result queue has room.
  assign go = !op_empty && !res_full;

  itrg_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (go),
    .op_i  (op_exe),
    .res_o (res)
  );

  // Result queue toward the consumer.
  itrg_fifo #(.item_t(item_out_t), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (go),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (out_item_o)
  );

endmodule

// File: sv/itrg_fifo.sv
// Small synchronous queue with a registered entry array.
module itrg_fifo import itrg_pkg::*; #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]    count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Occupancy follows the two handshakes.
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/itrg_front.sv
// Decoder that classifies each bus transaction into a timer operation.
module itrg_front import itrg_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  item_in_t item_i,
  output op_t      op_o
);

  logic [1:0] cmd_ch;
  logic [1:0] cmd_acc;

  assign cmd_ch  = item_i.write_data[7:6];
  assign cmd_acc = item_i.write_data[5:4];

  // Accesses to channels that are not built turn into no operation.
  always_comb begin
    op_o.kind = OP_NONE;
    op_o.ch   = item_i.port;
    op_o.data = item_i.write_data;
    unique case (item_i.opcode)
      OPC_WRITE: begin
        if (item_i.port == CMD_PORT) begin
          op_o.ch = cmd_ch;
          if (32'(cmd_ch) < NUM_CHANNELS) begin
            if (cmd_acc == ACC_LATCH) begin
              op_o.kind = OP_LATCH;
            end else if (cmd_acc == ACC_LOHI) begin
              op_o.kind = OP_MODE;
            end
          end
        end else if (32'(item_i.port) < NUM_CHANNELS) begin
          op_o.kind = OP_WRITE;
        end
      end
      OPC_READ: begin
        if (item_i.port != CMD_PORT && 32'(item_i.port) < NUM_CHANNELS) begin
          op_o.kind = OP_READ;
        end
      end
      OPC_TICK: begin
        op_o.kind = OP_TICK;
      end
      default: begin
        op_o.kind = OP_NONE;
      end
    endcase
  end

endmodule

// File: sv/itrg_back.sv
// Channel counters, byte access; one operation per cycle while go_i is set.
module itrg_back import itrg_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  op_t       op_i,
  output item_out_t res_o
);

  logic [BYTE_W-1:0]       rd_byte [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pulse;

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    logic [COUNT_W-1:0] reload_q, down_q, latched_q;
    logic [BYTE_W-1:0]  pend_q;
    logic               latch_valid_q, write_high_q, read_high_q, armed_q;
    logic               sel;
    logic [COUNT_W-1:0] read_val;

    assign sel      = go_i && (op_i.ch == 2'(c));
    assign read_val = latch_valid_q ? latched_q : down_q;

    // Byte returned on a data read of this channel.
    always_comb begin
      rd_byte[c] = '0;
      if (sel && op_i.kind == OP_READ) begin
        rd_byte[c] = read_high_q ? read_val[15:8] : read_val[7:0];
      end
    end

    // Reload flag on a tick when an armed count has reached one.
    assign pulse[c] = go_i && op_i.kind == OP_TICK && armed_q && (down_q == 16'd1);

    // Control flags and the live count.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        down_q        <= '0;
        latch_valid_q <= 1'b0;
        write_high_q  <= 1'b0;
        read_high_q   <= 1'b0;
        armed_q       <= 1'b0;
      end else if (go_i) begin
        case (op_i.kind)
          OP_LATCH: begin
            if (sel && !latch_valid_q) begin
              latch_valid_q <= 1'b1;
            end
          end
          OP_MODE: begin
            if (sel) begin
              armed_q       <= 1'b0;
              latch_valid_q <= 1'b0;
              write_high_q  <= 1'b0;
              read_high_q   <= 1'b0;
            end
          end
          OP_WRITE: begin
            if (sel) begin
              write_high_q <= !write_high_q;
              if (write_high_q) begin
                down_q  <= {op_i.data, pend_q};
                armed_q <= 1'b1;
              end
            end
          end
          OP_READ: begin
            if (sel) begin
              read_high_q <= !read_high_q;
              if (read_high_q) begin
                latch_valid_q <= 1'b0;
              end
            end
          end
          OP_TICK: begin
            if (armed_q) begin
              down_q <= (down_q == 16'd1) ? reload_q : down_q - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Held values, each read only after it has been written.
    always_ff @(posedge clk_i) begin
      if (sel && op_i.kind == OP_LATCH && !latch_valid_q) begin
        latched_q <= down_q;
      end
      if (sel && op_i.kind == OP_WRITE) begin
        if (write_high_q) begin
          reload_q <= {op_i.data, pend_q};
        end else begin
          pend_q <= op_i.data;
        end
      end
    end
  end

  // Merge the per-channel contributions into one result.
  always_comb begin
    res_o.read_data  = '0;
    res_o.pulse_mask = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      res_o.read_data     = res_o.read_data | rd_byte[c];
      res_o.pulse_mask[c] = pulse[c];
    end
  end

endmodule
